>>> rtl/core/vr_pkg.sv
// Package for the vector refraction pipeline: fixed-point formats, widths,
// the PIPE_LAT and SQRT_STAGES constants and the sideband type carried alongside the square root.
// No dependencies.
package vr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VEC_W     = 18;
  localparam int RATIO_W   = 19;

  // Intermediate widths, sized from the input ranges.
  localparam int PROD_W = 2 * VEC_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int COSV_W = DOT_W + 1;
  localparam int COS_W  = 22;
  localparam int CN_W   = COS_W + VEC_W;
  localparam int T_W    = 26;
  localparam int RT_W   = RATIO_W + 1 + T_W;
  localparam int P_W    = 26;
  localparam int SQ_W   = 2 * P_W - 1;
  localparam int LEN_W  = SQ_W + 2;
  localparam int RAD_W  = 2 * P_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int PAR_W  = ROOT_W + 1 + VEC_W;
  localparam int DIFF_W = PAR_W - FRAC_BITS + 1;

  localparam int SQRT_STAGES = ROOT_W / 2;
  localparam int PIPE_LAT    = 8 + SQRT_STAGES + 2;

  localparam longint unsigned HALF = 64'd1 << (FRAC_BITS - 1);
  localparam longint unsigned ONE  = 64'd1 << FRAC_BITS;
  localparam longint unsigned ONE2 = 64'd1 << (2 * FRAC_BITS);

  localparam longint signed OUT_MAX = (64'sd1 <<< (VEC_W - 1)) - 64'sd1;
  localparam longint signed OUT_MIN = -(64'sd1 <<< (VEC_W - 1));

  typedef struct packed {
    logic [2:0][VEC_W-1:0] nrm;
    logic [2:0][P_W-1:0]   perp;
  } side_t;

endpackage

>>> rtl/core/vr_sqrt.sv
// Pipelined integer square root, two result bits per register stage.
// Carries a sideband word alongside each beat. Depends on vr_pkg.
module vr_sqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [vr_pkg::RAD_W-1:0]  rad_i,
  input  vr_pkg::side_t         side_i,
  output logic                  vld_o,
  output logic [vr_pkg::ROOT_W-1:0] root_o,
  output vr_pkg::side_t         side_o
);
  import vr_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // One restoring step: bring down two radicand bits, try to subtract.
  function automatic sq_t sq_step(sq_t s, logic [1:0] pair);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    sq_t              r;
    cur   = {s.rem, pair};
    trial = (REM_W + 2)'({s.root, 2'b01});
    if (cur >= trial) begin
      r.rem  = REM_W'(cur - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur[REM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic             vld_q  [SQRT_STAGES];
  logic [RAD_W-1:0] rad_q  [SQRT_STAGES];
  sq_t              sq_q   [SQRT_STAGES];
  side_t            side_q [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic             vld_in;
    logic [RAD_W-1:0] rad_in;
    sq_t              sq_in;
    side_t            side_in;
    sq_t              sq_mid;
    sq_t              sq_d;

    if (g == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rad_in  = rad_i;
      assign sq_in   = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign sq_in   = sq_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      sq_mid = sq_step(sq_in, rad_in[RAD_W-1:RAD_W-2]);
      sq_d   = sq_step(sq_mid, rad_in[RAD_W-3:RAD_W-4]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[g]  <= {rad_in[RAD_W-5:0], 4'b0000};
      sq_q[g]   <= sq_d;
      side_q[g] <= side_in;
    end
  end

  assign vld_o  = vld_q[SQRT_STAGES-1];
  assign root_o = sq_q[SQRT_STAGES-1].root;
  assign side_o = side_q[SQRT_STAGES-1];

endmodule

>>> rtl/core/vector_refract.sv
// Snell refraction of a direction vector in fixed point (Q2.16 vectors).
// The result strobe done_o is registered in the same stage as the result beat.
// Throughput: one beat per cycle; busy stays low, since every stage advances
// each cycle and the receiver takes each result in the cycle it appears.
// The 23 register stages are 8 arithmetic, 13 square-root and 2 output stages.
// Reset clears all valid bits at once; payload registers are not reset.
module vector_refract (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [vr_pkg::VEC_W-1:0]     incident_x_i,
  input  logic signed [vr_pkg::VEC_W-1:0]     incident_y_i,
  input  logic signed [vr_pkg::VEC_W-1:0]     incident_z_i,
  input  logic signed [vr_pkg::VEC_W-1:0]     normal_x_i,
  input  logic signed [vr_pkg::VEC_W-1:0]     normal_y_i,
  input  logic signed [vr_pkg::VEC_W-1:0]     normal_z_i,
  input  logic        [vr_pkg::RATIO_W-1:0]   index_ratio_i,
  output logic                                done_o,
  output logic signed [vr_pkg::VEC_W-1:0]     refracted_x_o,
  output logic signed [vr_pkg::VEC_W-1:0]     refracted_y_o,
  output logic signed [vr_pkg::VEC_W-1:0]     refracted_z_o
);
  import vr_pkg::*;

  logic accept;
  logic signed [VEC_W-1:0] inc_in [3];
  logic signed [VEC_W-1:0] nrm_in [3];

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign inc_in[0] = incident_x_i;
  assign inc_in[1] = incident_y_i;
  assign inc_in[2] = incident_z_i;
  assign nrm_in[0] = normal_x_i;
  assign nrm_in[1] = normal_y_i;
  assign nrm_in[2] = normal_z_i;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v22_q, v23_q;

  // Stage registers. Normals travel with the beat through the square root.
  logic signed [PROD_W-1:0]  s1_prod_q [3];
  logic signed [VEC_W-1:0]   s1_inc_q [3], s2_inc_q [3], s3_inc_q [3];
  logic signed [VEC_W-1:0]   s1_nrm_q [3], s2_nrm_q [3], s3_nrm_q [3], s4_nrm_q [3];
  logic signed [VEC_W-1:0]   s5_nrm_q [3], s6_nrm_q [3], s7_nrm_q [3], s8_nrm_q [3];
  logic        [RATIO_W-1:0] s1_rat_q, s2_rat_q, s3_rat_q, s4_rat_q;
  logic signed [COS_W-1:0]   s2_cos_d, s2_cos_q;
  logic signed [CN_W-1:0]    s3_cn_q [3];
  logic signed [T_W-1:0]     s4_t_d [3], s4_t_q [3];
  logic signed [RT_W-1:0]    s5_rt_q [3];
  logic signed [P_W-1:0]     s6_p_d [3], s6_p_q [3], s7_p_q [3], s8_p_q [3];
  logic        [SQ_W-1:0]    s7_sq_d [3], s7_sq_q [3];
  logic        [RAD_W-1:0]   s8_rad_d, s8_rad_q;
  logic signed [PAR_W-1:0]   s22_par_q [3];
  logic signed [P_W-1:0]     s22_p_q [3];
  logic signed [VEC_W-1:0]   s23_out_d [3], s23_out_q [3];

  // Stage 2: dot product, negate, clamp to one, round.
  always_comb begin
    logic signed [DOT_W-1:0]  dot;
    logic signed [COSV_W-1:0] cosv;
    logic signed [COSV_W-1:0] cosr;
    dot  = DOT_W'(s1_prod_q[0]) + DOT_W'(s1_prod_q[1]) + DOT_W'(s1_prod_q[2]);
    cosv = -COSV_W'(dot);
    if (cosv > $signed(COSV_W'(ONE2))) begin
      cosv = $signed(COSV_W'(ONE2));
    end
    cosr     = (cosv + $signed(COSV_W'(HALF))) >>> FRAC_BITS;
    s2_cos_d = cosr[COS_W-1:0];
  end

  // Stages 4, 6, 7, 8: rounding, squares and the distance from one.
  always_comb begin
    logic signed [CN_W-1:0] cnr;
    logic signed [RT_W-1:0] rtr;
    logic signed [2*P_W-1:0] sq;
    logic [LEN_W-1:0] len2;
    logic [LEN_W-1:0] diff;
    for (int i = 0; i < 3; i++) begin
      cnr        = (s3_cn_q[i] + $signed(CN_W'(HALF))) >>> FRAC_BITS;
      s4_t_d[i]  = $signed(cnr[T_W-1:0]) + T_W'(s3_inc_q[i]);
      rtr        = (s5_rt_q[i] + $signed(RT_W'(HALF))) >>> FRAC_BITS;
      s6_p_d[i]  = rtr[P_W-1:0];
      sq         = s6_p_q[i] * s6_p_q[i];
      s7_sq_d[i] = sq[SQ_W-1:0];
    end
    len2 = LEN_W'(s7_sq_q[0]) + LEN_W'(s7_sq_q[1]) + LEN_W'(s7_sq_q[2]);
    if (len2 >= LEN_W'(ONE2)) begin
      diff = len2 - LEN_W'(ONE2);
    end else begin
      diff = LEN_W'(ONE2) - len2;
    end
    s8_rad_d = RAD_W'(diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s1_prod_q[i] <= inc_in[i] * nrm_in[i];
      s1_inc_q[i]  <= inc_in[i];
      s1_nrm_q[i]  <= nrm_in[i];
      s2_inc_q[i]  <= s1_inc_q[i];
      s2_nrm_q[i]  <= s1_nrm_q[i];
      s3_cn_q[i]   <= s2_cos_q * s2_nrm_q[i];
      s3_inc_q[i]  <= s2_inc_q[i];
      s3_nrm_q[i]  <= s2_nrm_q[i];
      s4_t_q[i]    <= s4_t_d[i];
      s4_nrm_q[i]  <= s3_nrm_q[i];
      s5_rt_q[i]   <= $signed({1'b0, s4_rat_q}) * s4_t_q[i];
      s5_nrm_q[i]  <= s4_nrm_q[i];
      s6_p_q[i]    <= s6_p_d[i];
      s6_nrm_q[i]  <= s5_nrm_q[i];
      s7_sq_q[i]   <= s7_sq_d[i];
      s7_p_q[i]    <= s6_p_q[i];
      s7_nrm_q[i]  <= s6_nrm_q[i];
      s8_p_q[i]    <= s7_p_q[i];
      s8_nrm_q[i]  <= s7_nrm_q[i];
    end
    s1_rat_q <= index_ratio_i;
    s2_rat_q <= s1_rat_q;
    s2_cos_q <= s2_cos_d;
    s3_rat_q <= s2_rat_q;
    s4_rat_q <= s3_rat_q;
    s8_rad_q <= s8_rad_d;
  end

  side_t              sq_side_in, sq_side_out;
  logic               sq_vld;
  logic [ROOT_W-1:0]  sq_root;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_side_in.nrm[i]  = s8_nrm_q[i];
      sq_side_in.perp[i] = s8_p_q[i];
    end
  end

  vr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v8_q),
    .rad_i  (s8_rad_q),
    .side_i (sq_side_in),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side_out)
  );

  // Output stage: round the normal component, subtract, saturate.
  always_comb begin
    logic signed [PAR_W-1:0]  parr;
    logic signed [DIFF_W-1:0] d;
    for (int i = 0; i < 3; i++) begin
      parr = (s22_par_q[i] + $signed(PAR_W'(HALF))) >>> FRAC_BITS;
      d    = DIFF_W'(s22_p_q[i]) - DIFF_W'(parr);
      if (d > $signed(DIFF_W'(OUT_MAX))) begin
        s23_out_d[i] = VEC_W'(OUT_MAX);
      end else if (d < $signed(DIFF_W'(OUT_MIN))) begin
        s23_out_d[i] = VEC_W'(OUT_MIN);
      end else begin
        s23_out_d[i] = d[VEC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v22_q <= 1'b0;
      v23_q <= 1'b0;
    end else begin
      v22_q <= sq_vld;
      v23_q <= v22_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s22_par_q[i] <= $signed({1'b0, sq_root}) * $signed(sq_side_out.nrm[i]);
      s22_p_q[i]   <= $signed(sq_side_out.perp[i]);
      s23_out_q[i] <= s23_out_d[i];
    end
  end

  assign done_o        = v23_q;
  assign refracted_x_o = s23_out_q[0];
  assign refracted_y_o = s23_out_q[1];
  assign refracted_z_o = s23_out_q[2];

endmodule

>>> rtl/core/vr_chk.sv
// Port-level checker for vector_refract, attached by the bind below.
// Depends on vr_pkg for the widths, PIPE_LAT and the fixed-point one.
module vr_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic signed [vr_pkg::VEC_W-1:0] incident_x_i,
  input logic signed [vr_pkg::VEC_W-1:0] incident_y_i,
  input logic signed [vr_pkg::VEC_W-1:0] incident_z_i,
  input logic signed [vr_pkg::VEC_W-1:0] normal_x_i,
  input logic signed [vr_pkg::VEC_W-1:0] normal_y_i,
  input logic signed [vr_pkg::VEC_W-1:0] normal_z_i,
  input logic [vr_pkg::RATIO_W-1:0]      index_ratio_i,
  input logic                            done_o,
  input logic signed [vr_pkg::VEC_W-1:0] refracted_x_o,
  input logic signed [vr_pkg::VEC_W-1:0] refracted_y_o,
  input logic signed [vr_pkg::VEC_W-1:0] refracted_z_o
);
  import vr_pkg::*;

  logic acc;
  logic flat_unit;
  logic flat_zero;

  assign acc = start && !busy;
  assign flat_unit = acc && normal_x_i == '0 && normal_y_i == '0 && normal_z_i == '0 &&
                     index_ratio_i == RATIO_W'(ONE);
  assign flat_zero = acc && normal_x_i == '0 && normal_y_i == '0 && normal_z_i == '0 &&
                     index_ratio_i == '0;

  // Every result beat comes from an accepted input beat.
  a_done_has_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, PIPE_LAT))
    else $error("result beat without a matching input beat");

  a_src_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##PIPE_LAT done_o)
    else $error("accepted beat produced no result");

  // A zero normal with unit ratio passes the incident direction through.
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(flat_unit, PIPE_LAT) |->
      refracted_x_o == $past(incident_x_i, PIPE_LAT) &&
      refracted_y_o == $past(incident_y_i, PIPE_LAT) &&
      refracted_z_o == $past(incident_z_i, PIPE_LAT))
    else $error("unit ratio with zero normal did not pass through");

  a_zero_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(flat_zero, PIPE_LAT) |->
      refracted_x_o == '0 && refracted_y_o == '0 && refracted_z_o == '0)
    else $error("zero ratio with zero normal gave a non-zero result");

endmodule

bind vector_refract vr_chk u_vr_chk (.*);

>>> test/tb_top.sv
// Self-checking testbench for vector_refract: directed and random rays go in,
// and each refracted direction is checked against a predictor kept in this file.
// Depends on vr_pkg and the vector_refract RTL only.
module tb_top;
  import vr_pkg::*;

  typedef struct {
    logic signed [VEC_W-1:0] inc [3];
    logic signed [VEC_W-1:0] nrm [3];
    logic [RATIO_W-1:0]      ratio;
    bit                      drain_first;
  } ray_t;

  typedef struct {
    logic signed [VEC_W-1:0] dir [3];
  } dir_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [VEC_W-1:0] incident_x_i = '0, incident_y_i = '0, incident_z_i = '0;
  logic signed [VEC_W-1:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic [RATIO_W-1:0] index_ratio_i = '0;
  logic done_o;
  logic signed [VEC_W-1:0] refracted_x_o, refracted_y_o, refracted_z_o;

  ray_t ray_q[$];
  dir_t refr_q[$];
  int   n_errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  bit   stim_done = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;

  vector_refract i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .incident_x_i, .incident_y_i, .incident_z_i,
    .normal_x_i, .normal_y_i, .normal_z_i,
    .index_ratio_i, .done_o,
    .refracted_x_o, .refracted_y_o, .refracted_z_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint rnd_fix(longint x);
    return (x + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic dir_t refract(ray_t r);
    dir_t d;
    longint i_v [3], n_v [3], p_v [3];
    longint dot, cosv, t, par, ratio, root_s;
    longint unsigned len2, diff, one2;
    dot = 0;
    len2 = 0;
    one2 = 64'd1 << (2 * FRAC_BITS);
    ratio = longint'(r.ratio);
    for (int k = 0; k < 3; k++) begin
      i_v[k] = longint'(r.inc[k]);
      n_v[k] = longint'(r.nrm[k]);
      dot += i_v[k] * n_v[k];
    end
    cosv = -dot;
    if (cosv > longint'(one2)) cosv = longint'(one2);
    cosv = rnd_fix(cosv);
    for (int k = 0; k < 3; k++) begin
      t = i_v[k] + rnd_fix(cosv * n_v[k]);
      p_v[k] = clip(rnd_fix(ratio * t), -64'sd2147483648, 64'sd2147483647);
      len2 += longint'(p_v[k] * p_v[k]);
    end
    diff = (len2 >= one2) ? len2 - one2 : one2 - len2;
    root_s = longint'(int_sqrt(diff));
    for (int k = 0; k < 3; k++) begin
      par = rnd_fix(root_s * n_v[k]);
      d.dir[k] = VEC_W'(clip(p_v[k] - par, OUT_MIN, OUT_MAX));
    end
    return d;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  function automatic ray_t mk_ray(longint ix, longint iy, longint iz, longint nx,
                                   longint ny, longint nz, longint ratio);
    ray_t r;
    r.inc[0] = VEC_W'(ix); r.inc[1] = VEC_W'(iy); r.inc[2] = VEC_W'(iz);
    r.nrm[0] = VEC_W'(nx); r.nrm[1] = VEC_W'(ny); r.nrm[2] = VEC_W'(nz);
    r.ratio = RATIO_W'(ratio);
    r.drain_first = 1'b0;
    return r;
  endfunction

  // Driver: records the beat accepted at this edge, then sets up the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        ray_t acc;
        acc = mk_ray(incident_x_i, incident_y_i, incident_z_i, normal_x_i,
                     normal_y_i, normal_z_i, index_ratio_i);
        refr_q.push_back(refract(acc));
        n_sent++;
      end
      if (start && busy) begin
        // hold the current beat
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (ray_q.size() == 0 ||
                   (ray_q[0].drain_first && (refr_q.size() != 0 || start))) begin
        start <= 1'b0;
      end else begin
        ray_t r;
        r = ray_q.pop_front();
        incident_x_i <= r.inc[0]; incident_y_i <= r.inc[1]; incident_z_i <= r.inc[2];
        normal_x_i <= r.nrm[0]; normal_y_i <= r.nrm[1]; normal_z_i <= r.nrm[2];
        index_ratio_i <= r.ratio;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (refr_q.size() == 0) begin
        report_mismatch("rays outstanding at a result", 0, 1);
      end else begin
        dir_t want;
        want = refr_q.pop_front();
        n_checked++;
        if (refracted_x_o !== want.dir[0]) report_mismatch("x", refracted_x_o, want.dir[0]);
        if (refracted_y_o !== want.dir[1]) report_mismatch("y", refracted_y_o, want.dir[1]);
        if (refracted_z_o !== want.dir[2]) report_mismatch("z", refracted_z_o, want.dir[2]);
      end
    end
  end

  initial begin
    ray_t r;
    longint one;
    one = longint'(ONE);
    // Directed: zeros, field extremes, head-on and grazing rays, ratio limits,
    // excess under the root (total internal reflection) and output saturation.
    ray_q.push_back(mk_ray(0, 0, 0, 0, 0, 0, 0));
    ray_q.push_back(mk_ray(0, 0, -one, 0, 0, one, one));
    ray_q.push_back(mk_ray(0, 0, -one, 0, 0, one, 524287));
    ray_q.push_back(mk_ray(46341, 0, -46341, 0, 0, one, one));
    ray_q.push_back(mk_ray(46341, 0, -46341, 0, 0, one, 3 * one / 2));
    ray_q.push_back(mk_ray(one, 0, -100, 0, 0, one, 2 * one));
    ray_q.push_back(mk_ray(46341, 0, -46341, 0, 0, one, one / 2));
    ray_q.push_back(mk_ray(0, 0, one, 0, 0, one, one));
    ray_q.push_back(mk_ray(131071, 131071, 131071, 131071, 131071, 131071, 524287));
    ray_q.push_back(mk_ray(-131072, -131072, -131072, -131072, -131072, -131072, 524287));
    ray_q.push_back(mk_ray(131071, -131072, 131071, -131072, 131071, -131072, 524287));
    ray_q.push_back(mk_ray(-131072, 131071, -131072, 131071, -131072, 131071, 0));
    ray_q.push_back(mk_ray(131071, 131071, 131071, -131072, -131072, -131072, 1));
    ray_q.push_back(mk_ray(0, 0, 0, 131071, 131071, 131071, 524287));
    ray_q.push_back(mk_ray(131071, 0, 0, 0, 0, 0, 524287));
    ray_q.push_back(mk_ray(-1, -1, -1, 1, 1, 1, one));
    ray_q.push_back(mk_ray(0, -one, 0, 0, one, 0, one + 1));
    ray_q.push_back(mk_ray(37837, -37837, -37837, 0, one, 0, 80000));
    for (int n = 0; n < 800; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        // Vectors with components in [-1, 1] and ratios from one half to two, as a renderer would send.
        r = mk_ray($urandom_range(0, 2 * one) - one, $urandom_range(0, 2 * one) - one,
                   $urandom_range(0, 2 * one) - one, $urandom_range(0, 2 * one) - one,
                   $urandom_range(0, 2 * one) - one, $urandom_range(0, 2 * one) - one,
                   $urandom_range(one / 2, 2 * one));
      end
      r.drain_first = (n == 400);
      ray_q.push_back(r);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    wait (ray_q.size() == 0 && !start && refr_q.size() == 0);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    $display("Sent %0d rays (directed extremes, grazing and reflecting cases, random),",
             n_sent);
    $display("checked %0d refracted directions, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && refr_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Timed out with %0d rays still outstanding.", refr_q.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/vr_pkg.sv
rtl/core/vr_sqrt.sv
rtl/core/vector_refract.sv
rtl/core/vr_chk.sv
test/tb_top.sv
